### rtl/core/pwfe_pkg.sv
// ----------------------------------------------------------------------------
// pwfe_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// pulse-width frame encoder.
// ----------------------------------------------------------------------------
package pwfe_pkg;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int unsigned BITS_PER_BYTE = 8;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned MARK_W = 16;
    localparam int unsigned DUR_W  = 20;
    localparam int unsigned IDX_W  = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_START_MARK = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPACE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_ONE_MARK   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ZERO_MARK  = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAP        = 3'd4;

    // Register reset values
    localparam logic [MARK_W-1:0] START_MARK_RST = 16'd2400;
    localparam logic [MARK_W-1:0] SPACE_RST      = 16'd600;
    localparam logic [MARK_W-1:0] ONE_MARK_RST   = 16'd1200;
    localparam logic [MARK_W-1:0] ZERO_MARK_RST  = 16'd600;
    localparam logic [DUR_W-1:0]  GAP_RST        = 20'd5000;

    // Segment layout: one unit of 19 segments, a byte is 18 of them plus a gap
    localparam int unsigned UNIT_SEGS = 19;
    localparam int unsigned SEG_W     = 5;
    localparam logic [SEG_W-1:0] SEG_LAST = 5'(UNIT_SEGS - 1);

    // Units of one job: data byte, CRC high byte, CRC low byte
    localparam logic [1:0] UNIT_DATA   = 2'd0;
    localparam logic [1:0] UNIT_CRC_HI = 2'd1;
    localparam logic [1:0] UNIT_CRC_LO = 2'd2;

    // Queue depth between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // One classified job handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              eof;
        logic [15:0]       crc;
    } job_t;

    // Configuration register set
    typedef struct packed {
        logic [MARK_W-1:0] start_mark_us;
        logic [MARK_W-1:0] space_us;
        logic [MARK_W-1:0] one_mark_us;
        logic [MARK_W-1:0] zero_mark_us;
        logic [DUR_W-1:0]  gap_us;
    } cfg_t;

    // Fold one byte into the running CRC, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < BITS_PER_BYTE; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/core/pulse_width_frame_encoder_crc16_unit.sv
// ----------------------------------------------------------------------------
// pulse_width_frame_encoder_crc16_unit
// Pulse-width carrier encoder for frame bytes with a CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Each pushed byte comes out as 19 carrier segments (start mark, space, eight
// LSB-first bit marks each followed by a space, then a gap); a byte pushed
// with end_of_frame adds an extra gap, the CRC high byte, a gap and the CRC
// low byte, 57 segments in all, and the CRC restarts at 0xFFFF. The segment
// sequencer emits one segment per cycle while the result register is empty
// or being popped; bytes are queued in a short job queue (QUEUE_DEPTH
// entries) so pushes overlap output of earlier bytes, and a result register
// lets the next segment be prepared while the current one waits for pop.
// last_segment marks the final segment of each pushed byte. Write the
// duration registers only while the block is idle.
module pulse_width_frame_encoder_crc16_unit
#(
    parameter int unsigned QUEUE_DEPTH = pwfe_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_frame,
    output logic                  empty,
    input  logic                  pop,
    output logic                  carrier_on,
    output logic [19:0]           duration_us,
    output logic                  last_segment,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [19:0]           cfg_data
);
    import pwfe_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    job_t  q_wr_job;
    logic  q_full;
    logic  q_pop;
    job_t  q_rd_job;
    logic  q_valid;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_MARK: cfg_next.start_mark_us = cfg_data[MARK_W-1:0];
                REG_SPACE:      cfg_next.space_us      = cfg_data[MARK_W-1:0];
                REG_ONE_MARK:   cfg_next.one_mark_us   = cfg_data[MARK_W-1:0];
                REG_ZERO_MARK:  cfg_next.zero_mark_us  = cfg_data[MARK_W-1:0];
                REG_GAP:        cfg_next.gap_us        = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_mark_us <= START_MARK_RST;
            cfg_reg.space_us      <= SPACE_RST;
            cfg_reg.one_mark_us   <= ONE_MARK_RST;
            cfg_reg.zero_mark_us  <= ZERO_MARK_RST;
            cfg_reg.gap_us        <= GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pwfe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_wr_job)
    );

    pwfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_job   (q_wr_job),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_job   (q_rd_job),
        .rd_valid (q_valid)
    );

    pwfe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_job        (q_rd_job),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .carrier_on   (carrier_on),
        .duration_us  (duration_us),
        .last_segment (last_segment)
    );

endmodule

### rtl/core/pwfe_front.sv
// ----------------------------------------------------------------------------
// pwfe_front
// Accepts frame bytes, runs the CRC and classifies each byte into a job
// (plain byte, or end-of-frame byte carrying the finished CRC).
// ----------------------------------------------------------------------------
module pwfe_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_frame,
    input  logic                  q_full,
    output logic                  q_push,
    output pwfe_pkg::job_t        q_job
);
    import pwfe_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_fed;
    logic        accept;

    assign accept  = push && !q_full;
    assign crc_fed = crc_feed(crc_reg, data_byte);

    // Build the job from the byte and the updated CRC
    assign q_push          = accept;
    assign q_job.data_byte = data_byte;
    assign q_job.eof       = end_of_frame;
    assign q_job.crc       = crc_fed;

    // Advance the CRC, restart it after the frame's last byte
    always_comb
    begin
        crc_next = crc_reg;
        if (accept)
        begin
            crc_next = end_of_frame ? CRC_INIT : crc_fed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

### rtl/core/pwfe_queue.sv
// ----------------------------------------------------------------------------
// pwfe_queue
// Short job queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module pwfe_queue
#(
    parameter int unsigned DEPTH = pwfe_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  pwfe_pkg::job_t        wr_job,
    output logic                  full,
    input  logic                  rd_en,
    output pwfe_pkg::job_t        rd_job,
    output logic                  rd_valid
);
    import pwfe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_MAX);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the job payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### rtl/core/pwfe_back.sv
// ----------------------------------------------------------------------------
// pwfe_back
// Segment sequencer: walks one job through its 19 or 57 carrier segments,
// one per cycle while the result register is empty or popped, into the result register.
// ----------------------------------------------------------------------------
module pwfe_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pwfe_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  pwfe_pkg::job_t        q_job,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic                  carrier_on,
    output logic [19:0]           duration_us,
    output logic                  last_segment
);
    import pwfe_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    job_t              job_reg;
    job_t              job_next;
    logic [1:0]        unit_reg;
    logic [1:0]        unit_next;
    logic [SEG_W-1:0]  seg_reg;
    logic [SEG_W-1:0]  seg_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_on_reg;
    logic              out_on_next;
    logic [DUR_W-1:0]  out_dur_reg;
    logic [DUR_W-1:0]  out_dur_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              advance;
    logic              is_gap;
    logic [SEG_W-1:0]  byte_seg;
    logic [7:0]        cur_byte;
    logic [2:0]        bit_idx;
    logic              cur_bit;
    logic              cur_on;
    logic [DUR_W-1:0]  cur_dur;
    logic              cur_last;
    logic              take;

    assign empty        = !out_valid_reg;
    assign carrier_on   = out_on_reg;
    assign duration_us  = out_dur_reg;
    assign last_segment = out_last_reg;

    // Result register frees up when empty or being read
    assign advance = !out_valid_reg || pop;

    // Decode the current segment: data unit ends in its gap, CRC units open with one
    always_comb
    begin
        if (unit_reg == UNIT_DATA)
        begin
            is_gap   = (seg_reg == SEG_LAST);
            byte_seg = seg_reg;
        end
        else
        begin
            is_gap   = (seg_reg == '0);
            byte_seg = seg_reg - 1'b1;
        end
        case (unit_reg)
            UNIT_DATA:   cur_byte = job_reg.data_byte;
            UNIT_CRC_HI: cur_byte = job_reg.crc[15:8];
            UNIT_CRC_LO: cur_byte = job_reg.crc[7:0];
            default:     cur_byte = job_reg.data_byte;
        endcase
        bit_idx = 3'(byte_seg[SEG_W-1:1] - 4'd1);
        cur_bit = cur_byte[bit_idx];
        if (is_gap)
        begin
            cur_on  = 1'b0;
            cur_dur = cfg.gap_us;
        end
        else if (byte_seg == '0)
        begin
            cur_on  = 1'b1;
            cur_dur = {4'd0, cfg.start_mark_us};
        end
        else if (byte_seg[0])
        begin
            cur_on  = 1'b0;
            cur_dur = {4'd0, cfg.space_us};
        end
        else
        begin
            cur_on  = 1'b1;
            cur_dur = cur_bit ? {4'd0, cfg.one_mark_us} : {4'd0, cfg.zero_mark_us};
        end
        cur_last = (seg_reg == SEG_LAST) && (!job_reg.eof || unit_reg == UNIT_CRC_LO);
    end

    // Take a new job when idle or when the last segment enters the result register this cycle
    assign take  = !busy_reg || (advance && cur_last);
    assign q_pop = take && q_valid;

    // Sequence segments and load the result register
    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        unit_next      = unit_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        out_on_next    = out_on_reg;
        out_dur_next   = out_dur_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = busy_reg;
            out_on_next    = cur_on;
            out_dur_next   = cur_dur;
            out_last_next  = cur_last;
            if (busy_reg && !cur_last)
            begin
                if (seg_reg == SEG_LAST)
                begin
                    seg_next  = '0;
                    unit_next = unit_reg + 1'b1;
                end
                else
                begin
                    seg_next = seg_reg + 1'b1;
                end
            end
        end
        if (take)
        begin
            busy_next = q_valid;
            if (q_valid)
            begin
                job_next  = q_job;
                unit_next = UNIT_DATA;
                seg_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            unit_reg      <= UNIT_DATA;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            unit_reg      <= unit_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold job and result payload
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_on_reg   <= out_on_next;
        out_dur_reg  <= out_dur_next;
        out_last_reg <= out_last_next;
    end

endmodule
